>>> design/grt_pkg.sv
package grt_pkg;

  // Coordinate words are 13 bits regardless of how many of them are fraction.
  localparam int COORD_W     = 13;
  localparam int CELL_OUT_W  = 5;
  // Error term width covers the widest fraction setting (16 bits).
  localparam int ERR_W       = 34;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = 7;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PREP,
    F_MUL,
    F_PUSH
  } grt_front_state_t;

  // One classified ray, ready for the walker. The err, x_gain and y_loss
  // fields are two's complement words of ERR_W bits.
  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] stop_x;
    logic [COORD_W-1:0] stop_y;
    logic               step_x;
    logic               dec_x;
    logic               step_y;
    logic               dec_y;
    logic               incl;
    logic [ERR_W-1:0]   err;
    logic [ERR_W-1:0]   x_gain;
    logic [ERR_W-1:0]   y_loss;
  } grt_job_t;

endpackage

>>> design/grt_if.sv
interface grt_ray_if;
  import grt_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic               include_end;

  modport source (output valid, start_x, start_y, end_x, end_y, include_end,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, include_end,
                output ready);
endinterface

interface grt_cell_if;
  import grt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CELL_OUT_W-1:0] cell_x;
  logic [CELL_OUT_W-1:0] cell_y;
  logic                  cell_valid;
  logic                  last_cell;

  modport source (output valid, cell_x, cell_y, cell_valid, last_cell,
                  input ready);
  modport sink (input valid, cell_x, cell_y, cell_valid, last_cell,
                output ready);
endinterface

>>> design/grt_front.sv
module grt_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  grt_ray_if.sink           ray,
  output logic              q_valid,
  input  logic              q_ready,
  output grt_pkg::grt_job_t q_job
);
  import grt_pkg::*;

  localparam int XW = COORD_W + FRAC_BITS;
  localparam int FW = FRAC_BITS + 1;
  localparam int PW = FW + COORD_W;

  grt_front_state_t state, state_next;

  logic [COORD_W-1:0] x0, y0, x1, y1;
  logic               incl;

  logic [COORD_W-1:0] dx, dy;
  logic [FW-1:0]      fx, fy;
  logic               sx, nx, sy, ny, bias;
  logic [COORD_W-1:0] cx0, cy0, cx1, cy1;

  logic [PW-1:0]      ex, ey;

  logic [XW-1:0]      x0e, y0e, x1e, y1e;
  logic [COORD_W-1:0] dx_c, dy_c;
  logic               sx_c, nx_c, sy_c, ny_c;
  logic [FW-1:0]      fx_c, fy_c;
  logic [FW-1:0]      one_c;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (ray.valid) state_next = F_PREP;
      F_PREP: state_next = F_MUL;
      F_MUL:  state_next = F_PUSH;
      F_PUSH: if (q_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    ray.ready = (state == F_IDLE);
    q_valid   = (state == F_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fractions and cell indices come from the coordinates widened past the
  // fraction field, so any fraction width works with 13-bit words.
  always_comb begin
    x0e   = XW'(x0);
    y0e   = XW'(y0);
    x1e   = XW'(x1);
    y1e   = XW'(y1);
    one_c = FW'(1) << FRAC_BITS;
    sx_c  = (x1 != x0);
    nx_c  = (x1 < x0);
    sy_c  = (y1 != y0);
    ny_c  = (y1 < y0);
    dx_c  = nx_c ? x0 - x1 : x1 - x0;
    dy_c  = ny_c ? y0 - y1 : y1 - y0;
    if (!sx_c) begin
      fx_c = '0;
    end else if (nx_c) begin
      fx_c = FW'(x0e[FRAC_BITS-1:0]);
    end else begin
      fx_c = one_c - FW'(x0e[FRAC_BITS-1:0]);
    end
    if (!sy_c) begin
      fy_c = '0;
    end else if (ny_c) begin
      fy_c = FW'(y0e[FRAC_BITS-1:0]);
    end else begin
      fy_c = one_c - FW'(y0e[FRAC_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (ray.valid && ray.ready) begin
      x0   <= ray.start_x;
      y0   <= ray.start_y;
      x1   <= ray.end_x;
      y1   <= ray.end_y;
      incl <= ray.include_end;
    end
    if (state == F_PREP) begin
      dx   <= dx_c;
      dy   <= dy_c;
      fx   <= fx_c;
      fy   <= fy_c;
      sx   <= sx_c;
      nx   <= nx_c;
      sy   <= sy_c;
      ny   <= ny_c;
      cx0  <= COORD_W'(x0e >> FRAC_BITS);
      cy0  <= COORD_W'(y0e >> FRAC_BITS);
      cx1  <= COORD_W'(x1e >> FRAC_BITS);
      cy1  <= COORD_W'(y1e >> FRAC_BITS);
      // Ties go to the y step when x falls toward a whole end row that is
      // itself left out.
      bias <= !incl && nx_c && (y1e[FRAC_BITS-1:0] == '0);
    end
    if (state == F_MUL) begin
      ex <= PW'(fx * dy);
      ey <= PW'(fy * dx);
    end
  end

  always_comb begin
    q_job.start_x = cx0;
    q_job.start_y = cy0;
    q_job.stop_x  = cx1;
    q_job.stop_y  = cy1;
    q_job.step_x  = sx;
    q_job.dec_x   = nx;
    q_job.step_y  = sy;
    q_job.dec_y   = ny;
    q_job.incl    = incl;
    q_job.err     = ((ERR_W'(ex) - ERR_W'(ey)) << 1) + ERR_W'(bias);
    q_job.x_gain  = ERR_W'(dy) << (FRAC_BITS + 1);
    q_job.y_loss  = ERR_W'(dx) << (FRAC_BITS + 1);
  end

endmodule

>>> design/grt_queue.sv
module grt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  grt_pkg::grt_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output grt_pkg::grt_job_t pop_job
);
  import grt_pkg::*;

  localparam int DEPTH = 2;

  grt_job_t   slots [DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'(DEPTH));
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'(DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

>>> design/grt_back.sv
module grt_back #(
  parameter int CAP = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  grt_pkg::grt_job_t q_job,
  grt_cell_if.source        visit
);
  import grt_pkg::*;

  logic               active;
  logic [CNT_W-1:0]   n;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [ERR_W-1:0]   err;
  grt_job_t           job;

  logic                  o_valid;
  logic [CELL_OUT_W-1:0] o_x, o_y;
  logic                  o_cv, o_last;

  logic               adv, at_end, empty, step_y, guard, new_end, cap_hit, last;
  logic [COORD_W-1:0] nx, ny;
  logic [ERR_W-1:0]   err_next;

  assign q_ready = !active;
  assign adv     = !o_valid || visit.ready;

  always_comb begin
    at_end  = (cur_x == job.stop_x) && (cur_y == job.stop_y);
    empty   = at_end && !job.incl;
    if (!job.step_y) begin
      step_y = 1'b0;
    end else if (!job.step_x) begin
      step_y = 1'b1;
    end else begin
      step_y = ($signed(err) > 0);
    end
    nx       = cur_x;
    ny       = cur_y;
    err_next = err;
    if (step_y) begin
      guard    = (cur_y == job.stop_y);
      ny       = job.dec_y ? cur_y - COORD_W'(1) : cur_y + COORD_W'(1);
      err_next = err - job.y_loss;
    end else begin
      guard    = !job.step_x || (cur_x == job.stop_x);
      nx       = job.dec_x ? cur_x - COORD_W'(1) : cur_x + COORD_W'(1);
      err_next = err + job.x_gain;
    end
    new_end = (nx == job.stop_x) && (ny == job.stop_y);
    cap_hit = (n == CNT_W'(CAP - 1));
    // Looking one step ahead marks the cell before an excluded end cell.
    last    = empty || at_end || cap_hit || guard || (new_end && !job.incl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (!active && q_valid) begin
        active <= 1'b1;
      end else if (active && adv && last) begin
        active <= 1'b0;
      end
      if (adv) begin
        o_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!active && q_valid) begin
      job   <= q_job;
      cur_x <= q_job.start_x;
      cur_y <= q_job.start_y;
      err   <= q_job.err;
      n     <= '0;
    end else if (active && adv) begin
      cur_x <= nx;
      cur_y <= ny;
      err   <= err_next;
      n     <= n + CNT_W'(1);
    end
    if (active && adv) begin
      o_x    <= empty ? '0 : cur_x[CELL_OUT_W-1:0];
      o_y    <= empty ? '0 : cur_y[CELL_OUT_W-1:0];
      o_cv   <= !empty;
      o_last <= last;
    end
  end

  assign visit.valid      = o_valid;
  assign visit.cell_x     = o_x;
  assign visit.cell_y     = o_y;
  assign visit.cell_valid = o_cv;
  assign visit.last_cell  = o_last;

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (visit.valid && !visit.cell_valid) |-> visit.last_cell)
    else $error("empty ray word not marked last");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    active |-> (n < CNT_W'(CAP)))
    else $error("result count passed the cap");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> (active && n == '0))
    else $error("job load did not start a walk");

endmodule

>>> design/grid_ray_cell_traversal.sv
// Grid ray traversal: walks a ray segment across a square grid and lists the
// cells it crosses, in order from the start cell toward the end cell.
//
// Input channel (ray): one word per ray, start and end points in unsigned
// fixed point with FRAC_BITS fraction bits, and include_end to also list the
// cell that holds the end point. Output channel (visit): one word per cell,
// with last_cell set on the final word of each ray. A ray that crosses no
// cell gives a single word with cell_valid clear.
//
// The front end takes a ray through capture, classify, multiply and hand-off,
// then pushes the job into the queue; the walker loads it from there, and
// each cell word it makes is held in the output register.
// Throughput: the walker emits one cell per cycle while the receiver takes
// them, and a ray gives at most 2*GRID_CELLS-1 result words (63 on the
// default grid). The front end runs ahead by up to two rays in the job queue.
//
// Reset (rst, synchronous) empties the queue and the output register; no
// clearing pass is needed. When the receiver stalls, the output register
// holds its word, the walker pauses, and the queue and front end keep
// accepting rays until the queue is full.
module grid_ray_cell_traversal #(
  parameter int GRID_CELLS = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  grt_ray_if.sink     ray,
  grt_cell_if.source  visit
);
  import grt_pkg::*;

  // A straight segment crosses at most 2*GRID_CELLS-1 cells.
  localparam int CAP = (2 * GRID_CELLS - 1 < MAX_RESULTS) ?
                       (2 * GRID_CELLS - 1) : MAX_RESULTS;

  logic     f_valid, f_ready;
  grt_job_t f_job;
  logic     b_valid, b_ready;
  grt_job_t b_job;

  // The front end turns endpoints into cell bounds, step directions and the
  // starting error term.
  grt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .ray     (ray),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_job   (f_job)
  );

  // The queue decouples setup from the walk so either side can stall alone.
  grt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_job    (b_job)
  );

  // The walker steps one cell per cycle on the sign of the error term while the output is not stalled.
  grt_back #(.CAP(CAP)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_job   (b_job),
    .visit   (visit)
  );

endmodule

>>> tb/grid_ray_cell_traversal_tb.sv
module grid_ray_cell_traversal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import grt_pkg::*;

  // The block is built with its default geometry: a 32 x 32 grid and
  // coordinates with eight fraction bits.
  localparam int GRID_CELLS = 32;
  localparam int FRAC_BITS  = 8;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int FMASK      = ONE - 1;
  localparam int COORD_MAX  = (1 << COORD_W) - 1;
  localparam int CELL_CAP   = (2 * GRID_CELLS - 1 < MAX_RESULTS) ?
                              2 * GRID_CELLS - 1 : MAX_RESULTS;

  // The watchdog trips when nothing moves on either channel while work is
  // outstanding and the quiet count reaches this limit. The slowest legal gap,
  // pipeline latency plus a long random stall, lies far below it.
  localparam int WATCHDOG_LIMIT = 3000;
  // After the last cell word the block is given this tail to show that it
  // sends nothing extra.
  localparam int TAIL_CYCLES    = 16;
  localparam int RANDOM_PER_PHASE = 96;

  // Step direction along one axis. The encoding packs the dec and step bits of
  // a walker job: up counts the cell index up, down counts it down.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd3
  } walk_dir_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               include_end;
  } ray_word_t;

  typedef struct packed {
    logic [CELL_OUT_W-1:0] cell_x;
    logic [CELL_OUT_W-1:0] cell_y;
    logic                  cell_valid;
    logic                  last_cell;
  } cell_word_t;

  logic clk;
  logic rst;

  grt_ray_if  ray_bus ();
  grt_cell_if visit_bus ();

  grid_ray_cell_traversal #(
    .GRID_CELLS(GRID_CELLS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .ray  (ray_bus),
    .visit(visit_bus)
  );

  // Rays waiting to be offered, the ray currently on the bus, and the cell
  // words the walk must still produce, oldest first.
  ray_word_t  pending_rays[$];
  ray_word_t  offered_ray;
  cell_word_t expected_cells[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int errors;
  int rays_sent;
  int cells_checked;
  int empty_rays;
  int tie_rays;
  int capped_rays;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Walks one ray across the grid exactly as the block should and appends
  // the cell words it must produce. The error term is held doubled so that
  // its low bit can carry the tie bias: when x falls toward a whole end row
  // and the end cell is left out, a corner crossing goes to y first.
  function automatic void trace_ray(ray_word_t r);
    int         x0, y0, x1, y1;
    int         dx, dy;
    int         cx, cy, stop_cx, stop_cy;
    int         n;
    walk_dir_t  dir_x, dir_y;
    longint     gain_x, gain_y, err;
    bit         at_end, move_y;
    cell_word_t path[CELL_CAP];
    x0 = r.start_x;
    y0 = r.start_y;
    x1 = r.end_x;
    y1 = r.end_y;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    dir_x = (dx == 0) ? DIR_NONE : ((x1 > x0) ? DIR_UP : DIR_DOWN);
    dir_y = (dy == 0) ? DIR_NONE : ((y1 > y0) ? DIR_UP : DIR_DOWN);
    cx = x0 >> FRAC_BITS;
    cy = y0 >> FRAC_BITS;
    stop_cx = x1 >> FRAC_BITS;
    stop_cy = y1 >> FRAC_BITS;

    // Distance to the first cell boundary on each axis, cross-multiplied by
    // the other axis length so that both sides share one scale.
    gain_x = 0;
    gain_y = 0;
    if (dir_x == DIR_UP) gain_x = longint'(ONE - (x0 & FMASK)) * dy;
    else if (dir_x == DIR_DOWN) gain_x = longint'(x0 & FMASK) * dy;
    if (dir_y == DIR_UP) gain_y = longint'(ONE - (y0 & FMASK)) * dx;
    else if (dir_y == DIR_DOWN) gain_y = longint'(y0 & FMASK) * dx;
    err = 2 * (gain_x - gain_y);
    if (!r.include_end && x1 < x0 && (y1 & FMASK) == 0) begin
      err = err + 1;
      tie_rays++;
    end

    n = 0;
    forever begin
      at_end = (cx == stop_cx) && (cy == stop_cy);
      if (at_end && !r.include_end) break;
      path[n] = '{cx[CELL_OUT_W-1:0], cy[CELL_OUT_W-1:0], 1'b1, 1'b0};
      n++;
      if (at_end) break;
      if (n >= CELL_CAP) begin
        capped_rays++;
        break;
      end
      // An axis with no length never steps; otherwise the error decides.
      if (dir_y == DIR_NONE) move_y = 1'b0;
      else if (dir_x == DIR_NONE) move_y = 1'b1;
      else move_y = (err > 0);
      if (move_y) begin
        // A step past the end row ends the walk.
        if (cy == stop_cy) break;
        cy = (dir_y == DIR_UP) ? cy + 1 : cy - 1;
        err = err - 2 * (longint'(dx) << FRAC_BITS);
      end else begin
        if (dir_x == DIR_NONE || cx == stop_cx) break;
        cx = (dir_x == DIR_UP) ? cx + 1 : cx - 1;
        err = err + 2 * (longint'(dy) << FRAC_BITS);
      end
    end

    // A ray that crosses nothing still answers with one word, cell_valid
    // clear, so that the receiver sees where each ray ends.
    if (n == 0) begin
      path[0] = '{'0, '0, 1'b0, 1'b0};
      n = 1;
    end
    for (int i = 0; i < n; i++) begin
      path[i].last_cell = (i == n - 1);
      expected_cells.push_back(path[i]);
    end
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  function automatic void queue_ray(int sx, int sy, int ex, int ey, bit incl);
    ray_word_t r;
    r.start_x = sx[COORD_W-1:0];
    r.start_y = sy[COORD_W-1:0];
    r.end_x = ex[COORD_W-1:0];
    r.end_y = ey[COORD_W-1:0];
    r.include_end = incl;
    pending_rays.push_back(r);
  endfunction

  // Random rays come in several flavors. Short rays keep the walk busy with
  // many small jobs, long ones reach the length cap, whole coordinates make
  // exact corner crossings and so exercise the tie handling, and the rest
  // cover lines along an axis, rays inside one cell and fractions at their
  // extremes.
  function automatic void queue_random_ray();
    int          sx, sy, ex, ey, span;
    int unsigned kind;
    sx = $urandom_range(COORD_MAX);
    sy = $urandom_range(COORD_MAX);
    ex = $urandom_range(COORD_MAX);
    ey = $urandom_range(COORD_MAX);
    kind = $urandom_range(9);
    case (kind) inside
      [0:3]: begin
        span = $urandom_range(4, 1) * ONE;
        ex = clamp_coord(sx + $urandom_range(2 * span) - span);
        ey = clamp_coord(sy + $urandom_range(2 * span) - span);
      end
      6: begin
        sx = sx & ~FMASK;
        sy = sy & ~FMASK;
        ex = ex & ~FMASK;
        ey = ey & ~FMASK;
      end
      7: begin
        if ($urandom_range(1)) ey = sy;
        else ex = sx;
      end
      8: begin
        // Either the very same point or another point in the start cell.
        ex = (sx & ~FMASK) | ($urandom_range(1) ? (sx & FMASK) : $urandom_range(FMASK));
        ey = (sy & ~FMASK) | ($urandom_range(1) ? (sy & FMASK) : $urandom_range(FMASK));
      end
      9: begin
        sx = (sx & ~FMASK) | ($urandom_range(1) ? FMASK : 0);
        sy = (sy & ~FMASK) | ($urandom_range(1) ? FMASK : 0);
        ex = (ex & ~FMASK) | ($urandom_range(1) ? FMASK : 0);
        ey = (ey & ~FMASK) | ($urandom_range(1) ? FMASK : 0);
      end
      default: begin
      end
    endcase
    queue_ray(sx, sy, ex, ey, 1'($urandom_range(1)));
  endfunction

  // Ray driver. A word stays on the bus until the block takes it; a new one
  // is offered in the cycle after the handshake unless the sender idles.
  // The prediction is made when the word is accepted.
  always @(posedge clk) begin
    if (rst) begin
      ray_bus.valid <= 1'b0;
    end else begin
      if (ray_bus.valid && ray_bus.ready) begin
        trace_ray(offered_ray);
        rays_sent++;
      end
      if (!ray_bus.valid || ray_bus.ready) begin
        if (pending_rays.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_ray = pending_rays.pop_front();
          ray_bus.valid       <= 1'b1;
          ray_bus.start_x     <= offered_ray.start_x;
          ray_bus.start_y     <= offered_ray.start_y;
          ray_bus.end_x       <= offered_ray.end_x;
          ray_bus.end_y       <= offered_ray.end_y;
          ray_bus.include_end <= offered_ray.include_end;
        end else begin
          ray_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Cell monitor. Every accepted cell word is matched against the oldest
  // expected word; ready is redrawn each cycle to stall the walker at random.
  always @(posedge clk) begin
    cell_word_t got, want;
    if (rst) begin
      visit_bus.ready <= 1'b0;
    end else begin
      if (visit_bus.valid && visit_bus.ready) begin
        got = '{visit_bus.cell_x, visit_bus.cell_y, visit_bus.cell_valid,
                visit_bus.last_cell};
        if (expected_cells.size() == 0) begin
          $display("%0t: cell word with nothing expected: x=%0d y=%0d valid=%0b last=%0b",
                   $time, got.cell_x, got.cell_y, got.cell_valid, got.last_cell);
          errors++;
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            $display("%0t: cell mismatch: expected x=%0d y=%0d valid=%0b last=%0b,",
                     $time, want.cell_x, want.cell_y, want.cell_valid, want.last_cell,
                     " got x=%0d y=%0d valid=%0b last=%0b",
                     got.cell_x, got.cell_y, got.cell_valid, got.last_cell);
            errors++;
          end
          cells_checked++;
          if (!want.cell_valid) empty_rays++;
        end
      end
      visit_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: counts cycles in which work is outstanding but no word moves on
  // either channel.
  always @(posedge clk) begin
    if (rst || (ray_bus.valid && ray_bus.ready) || (visit_bus.valid && visit_bus.ready) ||
        (pending_rays.size() == 0 && !ray_bus.valid && expected_cells.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d cell words still expected",
               $time, WATCHDOG_LIMIT, expected_cells.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus. Four idling phases run back to back: free flow, a sender that
  // idles about half the time, a receiver that stalls about half the time,
  // and both at once at a lighter rate. Each phase drains completely before
  // the next one starts. The directed rays go first, in the free-flow phase.
  initial begin
    rst = 1'b1;
    ray_bus.valid = 1'b0;
    ray_bus.start_x = '0;
    ray_bus.start_y = '0;
    ray_bus.end_x = '0;
    ray_bus.end_y = '0;
    ray_bus.include_end = 1'b0;
    visit_bus.ready = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    errors = 0;
    rays_sent = 0;
    cells_checked = 0;
    empty_rays = 0;
    tie_rays = 0;
    capped_rays = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 53;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 53;
        end
        default: begin
          sender_idle_pct = 22;
          receiver_stall_pct = 22;
        end
      endcase

      if (phase == 0) begin
        // Corner to corner in all four diagonal directions.
        queue_ray(0, 0, COORD_MAX, COORD_MAX, 1'b1);
        queue_ray(COORD_MAX, COORD_MAX, 0, 0, 1'b1);
        queue_ray(0, COORD_MAX, COORD_MAX, 0, 1'b0);
        queue_ray(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
        // Identical points: one cell when the end is included, else none.
        queue_ray('h1234, 'h0ABC, 'h1234, 'h0ABC, 1'b1);
        queue_ray('h1234, 'h0ABC, 'h1234, 'h0ABC, 1'b0);
        // Distinct points inside one cell, end excluded: no cells.
        queue_ray('h0510, 'h0520, 'h05F0, 'h05E0, 1'b0);
        // Lines along each axis, both directions.
        queue_ray('h0105, 'h0733, 'h1F80, 'h0733, 1'b1);
        queue_ray('h1F80, 'h0733, 'h0105, 'h0733, 1'b0);
        queue_ray('h0A0A, 'h0011, 'h0A0A, 'h1E40, 1'b1);
        queue_ray('h0A0A, 'h1E40, 'h0A0A, 'h0011, 1'b0);
        queue_ray(COORD_MAX, 0, COORD_MAX, COORD_MAX, 1'b1);
        // Exact corner crossings with x falling toward a whole end row: the
        // tie goes to y when the end cell is excluded, to x when included.
        queue_ray('h0300, 'h0300, 'h0100, 'h0100, 1'b0);
        queue_ray('h0300, 'h0300, 'h0100, 'h0100, 1'b1);
        queue_ray('h0300, 'h0100, 'h0100, 'h0300, 1'b0);
        // An exact corner tie with x rising goes to x; then x falls.
        queue_ray('h0080, 'h0080, 'h0280, 'h0280, 1'b0);
        queue_ray('h05A0, 'h0900, 'h0210, 'h0400, 1'b0);
        // End point, then start point, on a whole column boundary.
        queue_ray('h0040, 'h0040, 'h0400, 'h00C0, 1'b0);
        queue_ray('h0400, 'h00C0, 'h0040, 'h0040, 1'b0);
      end
      repeat (RANDOM_PER_PHASE) queue_random_ray();

      // Let the phase drain, then give the walker time to show any stray word.
      while (pending_rays.size() != 0 || ray_bus.valid || expected_cells.size() != 0)
        @(posedge clk);
      repeat (TAIL_CYCLES) @(posedge clk);
    end

    $display("Walked %0d rays over four idling phases: %0d cell words checked,", rays_sent,
             cells_checked);
    $display("%0d rays with no cells, %0d with the tie bias, %0d stopped by the length cap.",
             empty_rays, tie_rays, capped_rays);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
